[rtl/core/fixed_block_free_list_allocator_defines.svh]
// assertion macros for the free list allocator
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define FBFLA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// same check, also active while reset is applied
`define FBFLA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");
`else
`define FBFLA_ASSERT(lbl, prop)
`define FBFLA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/core/fbfla_pkg.sv]
// types, constants and block layout tables for the free list allocator
package fbfla_pkg;

  localparam int PoolBytes   = 4096;
  localparam int SmallBytes  = 15;
  localparam int LargeBytes  = 180;
  localparam int HeaderBytes = 16;
  localparam int BlkW        = 5;
  localparam int MaxBlocks   = 2 ** BlkW;
  localparam int StepW       = BlkW + 1;
  localparam int SizeW       = 8;
  localparam int OfsW        = 12;
  localparam int ReqW        = 16;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [ReqW-1:0] request_size;
    logic            handle_present;
    logic [BlkW-1:0] block_handle;
  } fbfla_req_t;

  typedef struct packed {
    logic            granted;
    logic [BlkW-1:0] block_index;
    logic [OfsW-1:0] data_offset;
  } fbfla_rsp_t;

  // one entry of the link store
  typedef struct packed {
    logic            valid;
    logic [BlkW-1:0] link;
  } fbfla_link_t;

  typedef logic [SizeW-1:0] size_tab_t [MaxBlocks];
  typedef logic [OfsW-1:0]  ofs_tab_t  [MaxBlocks];

  function automatic int blk_count_f();
    int pos;
    int n;
    pos = 0;
    n   = 0;
    for (int k = 0; k < MaxBlocks; k++) begin
      if (pos + HeaderBytes + SmallBytes <= PoolBytes) begin
        if (pos + HeaderBytes + LargeBytes <= PoolBytes) begin
          pos = pos + HeaderBytes + LargeBytes;
        end else begin
          pos = pos + HeaderBytes + SmallBytes;
        end
        n++;
      end
    end
    return n;
  endfunction

  function automatic size_tab_t size_tab_f();
    size_tab_t   tab;
    int          pos;
    logic [31:0] v;
    pos = 0;
    for (int k = 0; k < MaxBlocks; k++) begin
      tab[k] = '0;
      if (pos + HeaderBytes + SmallBytes <= PoolBytes) begin
        if (pos + HeaderBytes + LargeBytes <= PoolBytes) begin
          v = 32'(LargeBytes);
        end else begin
          v = 32'(SmallBytes);
        end
        tab[k] = v[SizeW-1:0];
        pos = pos + HeaderBytes + int'(v);
      end
    end
    return tab;
  endfunction

  function automatic ofs_tab_t ofs_tab_f();
    ofs_tab_t    tab;
    int          pos;
    logic [31:0] v;
    pos = 0;
    for (int k = 0; k < MaxBlocks; k++) begin
      tab[k] = '0;
      if (pos + HeaderBytes + SmallBytes <= PoolBytes) begin
        v      = 32'(pos + HeaderBytes);
        tab[k] = v[OfsW-1:0];
        if (pos + HeaderBytes + LargeBytes <= PoolBytes) begin
          pos = pos + HeaderBytes + LargeBytes;
        end else begin
          pos = pos + HeaderBytes + SmallBytes;
        end
      end
    end
    return tab;
  endfunction

  localparam int        BlkCount = blk_count_f();
  localparam size_tab_t SizeTab  = size_tab_f();
  localparam ofs_tab_t  OfsTab   = ofs_tab_f();

  localparam logic [StepW-1:0] BlkCountS = StepW'(BlkCount);
  localparam logic [BlkW-1:0]  TopBlk    = (BlkCount > 0) ? BlkW'(BlkCount - 1) : '0;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StWalk = 2'b10
  } fbfla_state_e;

endpackage

[rtl/core/fbfla_ram.sv]
// generic simple dual port ram with registered read
module fbfla_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/fixed_block_free_list_allocator.sv]
// free list allocator top level: link store, walk sequencer, result register
//
// channel  dir  handshake                payload
// in       in   in_valid_i / in_stall_o   fbfla_req_t in_data_i
// out      out  out_valid_o / out_stall_i fbfla_rsp_t out_data_o
//
// a granted free writes the link store in the transfer cycle.
// an allocate follows k links of the list (at most 25 here),
// one link per cycle through the registered read port of the link store.
// after reset the link store is undefined; per-entry written bits supply
// the initial downward chain, so no clearing pass is needed.
// input stalls while a walk runs or while a finished result is stalled.
`include "fixed_block_free_list_allocator_defines.svh"

module fixed_block_free_list_allocator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fbfla_pkg::fbfla_req_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fbfla_pkg::fbfla_rsp_t out_data_o
);
  import fbfla_pkg::*;

  fbfla_state_e         state_q, state_d;
  logic [BlkW-1:0]      head_q, head_d;
  logic                 head_valid_q, head_valid_d;
  logic [MaxBlocks-1:0] written_q, written_d;
  logic [BlkW-1:0]      cur_q, cur_d;
  logic [BlkW-1:0]      prev_q, prev_d;
  logic                 prev_is_head_q, prev_is_head_d;
  logic                 have_q, have_d;
  logic [StepW-1:0]     steps_q, steps_d;
  logic [ReqW-1:0]      req_q, req_d;
  logic                 out_valid_q, out_valid_d;
  fbfla_rsp_t           out_data_q, out_data_d;

  logic                 in_xfer;
  logic                 out_xfer;
  logic                 ram_we;
  logic [BlkW-1:0]      ram_waddr;
  fbfla_link_t          ram_wdata;
  logic [BlkW-1:0]      ram_raddr;
  fbfla_link_t          ram_rdata;
  fbfla_link_t          cur_link;
  logic                 cur_in_range;
  logic                 size_match;
  logic                 walk_fail;
  logic                 free_ok;

  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;

  fbfla_ram #(
    .Width ($bits(fbfla_link_t)),
    .Depth (MaxBlocks)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // link of the block under inspection; unwritten entries chain downward
  always_comb begin
    if (written_q[cur_q]) begin
      cur_link = ram_rdata;
    end else begin
      cur_link.link  = (cur_q != '0) ? cur_q - BlkW'(1) : '0;
      cur_link.valid = (cur_q != '0) && ({1'b0, cur_q} < BlkCountS);
    end
  end

  assign cur_in_range = {1'b0, cur_q} < BlkCountS;
  assign size_match   = {{(ReqW-SizeW){1'b0}}, SizeTab[cur_q]} == req_q;
  assign walk_fail    = !have_q || (steps_q >= BlkCountS) || !cur_in_range;
  assign free_ok      = in_data_i.handle_present &&
                        ({1'b0, in_data_i.block_handle} < BlkCountS);

  assign ram_raddr = (state_q == StWalk) ? cur_link.link : head_q;

  always_comb begin
    state_d        = state_q;
    head_d         = head_q;
    head_valid_d   = head_valid_q;
    written_d      = written_q;
    cur_d          = cur_q;
    prev_d         = prev_q;
    prev_is_head_d = prev_is_head_q;
    have_d         = have_q;
    steps_d        = steps_q;
    req_d          = req_q;
    out_valid_d    = out_valid_q && !out_xfer;
    out_data_d     = out_data_q;
    ram_we         = 1'b0;
    ram_waddr      = prev_q;
    ram_wdata      = cur_link;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (in_data_i.opcode == OpFree) begin
            out_valid_d = 1'b1;
            out_data_d  = '0;
            if (free_ok) begin
              ram_we                 = 1'b1;
              ram_waddr              = in_data_i.block_handle;
              ram_wdata.link         = head_q;
              ram_wdata.valid        = head_valid_q;
              written_d[in_data_i.block_handle] = 1'b1;
              head_d                 = in_data_i.block_handle;
              head_valid_d           = 1'b1;
              out_data_d.granted     = 1'b1;
              out_data_d.block_index = in_data_i.block_handle;
              out_data_d.data_offset = OfsTab[in_data_i.block_handle];
            end
          end else begin
            // read of the head entry is issued in this cycle
            cur_d          = head_q;
            have_d         = head_valid_q;
            prev_is_head_d = 1'b1;
            steps_d        = '0;
            req_d          = in_data_i.request_size;
            state_d        = StWalk;
          end
        end
      end
      StWalk: begin
        if (walk_fail) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          state_d     = StIdle;
        end else if (size_match) begin
          // unlink the matching block
          if (prev_is_head_q) begin
            head_d       = cur_link.link;
            head_valid_d = cur_link.valid;
          end else begin
            ram_we            = 1'b1;
            written_d[prev_q] = 1'b1;
          end
          out_valid_d            = 1'b1;
          out_data_d.granted     = 1'b1;
          out_data_d.block_index = cur_q;
          out_data_d.data_offset = OfsTab[cur_q];
          state_d                = StIdle;
        end else begin
          prev_d         = cur_q;
          prev_is_head_d = 1'b0;
          have_d         = cur_link.valid;
          cur_d          = cur_link.link;
          steps_d        = steps_q + StepW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      head_q       <= TopBlk;
      head_valid_q <= (BlkCount > 0);
      written_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      written_q    <= written_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q          <= cur_d;
    prev_q         <= prev_d;
    prev_is_head_q <= prev_is_head_d;
    have_q         <= have_d;
    steps_q        <= steps_d;
    req_q          <= req_d;
    out_data_q     <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a walk never follows more links than there are blocks
  `FBFLA_ASSERT(a_steps_bound, (state_q == StWalk) |-> (steps_q <= BlkCountS))

  // an allocate transfer starts a walk
  `FBFLA_ASSERT(a_alloc_walks,
    (in_xfer && (in_data_i.opcode == OpAlloc)) |=> (state_q == StWalk))

  // a granted free puts the handle at the head of the list
  `FBFLA_ASSERT(a_free_head,
    (in_xfer && (in_data_i.opcode == OpFree) && free_ok) |=>
      (head_valid_q && (head_q == $past(in_data_i.block_handle))))

  // a refused request carries zero fields
  `FBFLA_ASSERT(a_refused_zero,
    (out_valid_q && !out_data_q.granted) |->
      ((out_data_q.block_index == '0) && (out_data_q.data_offset == '0)))

  // a new result appears only after a free transfer or the end of a walk
  `FBFLA_ASSERT(a_result_source,
    $rose(out_valid_q) |-> $past(in_xfer || (state_q == StWalk)))

endmodule
